// ----- src/ssa_pkg.sv -----
package ssa_pkg;

  // Operation codes of a request
  typedef enum logic [1:0] {
    OpAlloc  = 2'd0,
    OpRewind = 2'd1,
    OpReset  = 2'd2,
    OpNone   = 2'd3
  } op_e;

  // Status codes of a result
  typedef enum logic [2:0] {
    StOk        = 3'd0,
    StOverflow  = 3'd1,
    StCapacity  = 3'd2,
    StBeyond    = 3'd3,
    StSplit     = 3'd4,
    StStackFull = 3'd5
  } status_e;

  // Configuration register indexes
  localparam logic CfgCapacity  = 1'b0;
  localparam logic CfgAlignment = 1'b1;

  // Datapath widths
  localparam int unsigned DataW    = 32;
  localparam int unsigned AlignW   = 16;
  // Wide enough for any offset plus pad plus size
  localparam int unsigned SumW     = 34;
  localparam int unsigned DivSteps = DataW;
  localparam int unsigned DivCntW  = $clog2(DivSteps);

  localparam logic [DataW-1:0]  CapacityReset  = 32'd65536;
  localparam logic [AlignW-1:0] AlignmentReset = 16'd16;

endpackage

// ----- src/scratch_stack_allocator.sv -----
// Channel   | Ports                                         | Direction | Handshake
// ----------+-----------------------------------------------+-----------+----------------------
// request   | start_i, operation_i, request_size_i,         | in        | start_i && !busy_o
//           | rewind_mark_i                                 |           |
// result    | done_o, status_o, granted_offset_o,           | out       | done_o, one cycle
//           | used_bytes_o, peak_bytes_o                    |           |
// config    | cfg_valid_i, cfg_ready_o, cfg_index_i,        | in        | cfg_valid_i && ready
//           | cfg_data_i                                    |           |
//
// An allocate runs a bit-serial remainder of the used pointer by the alignment, then forms the
// padded offset, then checks and commits. A rewind pops records from the record memory (one
// read, one compare per record) and ends without a further read when the pops empty the stack;
// a rewind to a mark beyond the used pointer, a reset or an unused code answers straight from
// the idle state.
// Reset clears the used pointer, peak and record count and loads the default configuration at
// once; the record memory needs no clearing pass. Configuration writes are held off while a
// request is in flight. The receiver cannot stall: each result is shown once.
module scratch_stack_allocator #(
  parameter int unsigned MAX_RECORDS = 64,
  parameter int unsigned ADDR_BITS   = 32
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  output logic                            busy_o,
  input  ssa_pkg::op_e                    operation_i,
  input  logic [31:0]                     request_size_i,
  input  logic [31:0]                     rewind_mark_i,
  output logic                            done_o,
  output ssa_pkg::status_e                status_o,
  output logic [31:0]                     granted_offset_o,
  output logic [31:0]                     used_bytes_o,
  output logic [31:0]                     peak_bytes_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic                            cfg_index_i,
  input  logic [31:0]                     cfg_data_i
);
  import ssa_pkg::*;

  localparam int unsigned IdxW = (MAX_RECORDS > 1) ? $clog2(MAX_RECORDS) : 1;
  localparam int unsigned CntW = $clog2(MAX_RECORDS + 1);
  localparam logic [CntW-1:0] MaxCnt = CntW'(MAX_RECORDS);
  localparam logic [SumW-1:0] Limit =
      (ADDR_BITS >= SumW) ? {SumW{1'b1}} : ((SumW'(1) << ADDR_BITS) - SumW'(1));

  // State codes
  localparam logic [2:0] SIdle  = 3'd0;
  localparam logic [2:0] SDiv   = 3'd1;
  localparam logic [2:0] SPad   = 3'd2;
  localparam logic [2:0] SCheck = 3'd3;
  localparam logic [2:0] SRwRd  = 3'd4;
  localparam logic [2:0] SRwChk = 3'd5;

  logic [2:0]         state_q, state_d;
  logic [DataW-1:0]   used_q, used_d;
  logic [DataW-1:0]   peak_q, peak_d;
  logic [CntW-1:0]    count_q, count_d;
  logic [DataW-1:0]   cap_q;
  logic [AlignW-1:0]  align_q;
  logic               done_q, done_d;
  status_e            status_q, status_d;
  logic [DataW-1:0]   goff_q, goff_d;

  logic [DataW-1:0]   size_q, size_d;
  logic [DataW-1:0]   mark_q, mark_d;
  logic [DataW-1:0]   dvd_q, dvd_d;
  logic [AlignW-1:0]  rem_q, rem_d;
  logic [DivCntW-1:0] dcnt_q, dcnt_d;
  logic [SumW-1:0]    off_q, off_d;
  logic               ovf_q, ovf_d;

  // Record memory: size in the upper half, offset in the lower
  logic [2*DataW-1:0] rec_mem [MAX_RECORDS];
  logic [2*DataW-1:0] rd_data_q;
  logic               rd_en, wr_en;
  logic [IdxW-1:0]    rd_addr, wr_addr;
  logic [2*DataW-1:0] wr_data;

  logic [AlignW-1:0]  al_eff;
  logic [AlignW:0]    trial;
  logic [AlignW-1:0]  pad;
  logic [SumW-1:0]    end_sum;
  logic [DataW:0]     top_end;
  logic [CntW-1:0]    count_m1;

  assign busy_o           = (state_q != SIdle);
  assign cfg_ready_o      = !busy_o;
  assign done_o           = done_q;
  assign status_o         = status_q;
  assign granted_offset_o = goff_q;
  assign used_bytes_o     = used_q;
  assign peak_bytes_o     = peak_q;

  // Zero alignment acts as one
  assign al_eff   = (align_q == '0) ? AlignW'(1) : align_q;
  assign trial    = {rem_q, dvd_q[DataW-1]};
  assign pad      = (rem_q == '0) ? '0 : al_eff - rem_q;
  assign end_sum  = off_q + SumW'(size_q);
  assign top_end  = {1'b0, rd_data_q[DataW-1:0]} + {1'b0, rd_data_q[2*DataW-1:DataW]};
  assign count_m1 = count_q - CntW'(1);
  assign rd_addr  = count_m1[IdxW-1:0];
  assign wr_addr  = count_q[IdxW-1:0];
  assign wr_data  = {size_q, off_q[DataW-1:0]};

  // Sequence one request through division, checks and record pops
  always_comb begin
    state_d  = state_q;
    used_d   = used_q;
    peak_d   = peak_q;
    count_d  = count_q;
    done_d   = 1'b0;
    status_d = status_q;
    goff_d   = goff_q;
    size_d   = size_q;
    mark_d   = mark_q;
    dvd_d    = dvd_q;
    rem_d    = rem_q;
    dcnt_d   = dcnt_q;
    off_d    = off_q;
    ovf_d    = ovf_q;
    rd_en    = 1'b0;
    wr_en    = 1'b0;

    unique case (state_q)
      SIdle: begin
        if (start_i) begin
          size_d   = request_size_i;
          mark_d   = rewind_mark_i;
          status_d = StOk;
          goff_d   = '0;
          unique case (operation_i)
            OpAlloc: begin
              dvd_d   = used_q;
              rem_d   = '0;
              dcnt_d  = '0;
              state_d = SDiv;
            end
            OpRewind: begin
              if (rewind_mark_i > used_q) begin
                status_d = StBeyond;
                done_d   = 1'b1;
              end else begin
                state_d = SRwRd;
              end
            end
            OpReset: begin
              used_d  = '0;
              count_d = '0;
              done_d  = 1'b1;
            end
            default: begin
              done_d = 1'b1;
            end
          endcase
        end
      end

      // One remainder bit a cycle
      SDiv: begin
        if (trial >= {1'b0, al_eff}) begin
          rem_d = AlignW'(trial - {1'b0, al_eff});
        end else begin
          rem_d = trial[AlignW-1:0];
        end
        dvd_d  = {dvd_q[DataW-2:0], 1'b0};
        dcnt_d = dcnt_q + DivCntW'(1);
        if (dcnt_q == DivCntW'(DivSteps - 1)) begin
          state_d = SPad;
        end
      end

      // Round the used pointer up
      SPad: begin
        off_d   = SumW'(used_q) + SumW'(pad);
        ovf_d   = (SumW'(used_q) + SumW'(pad)) > Limit;
        state_d = SCheck;
      end

      // Check the new block and commit it
      SCheck: begin
        done_d  = 1'b1;
        state_d = SIdle;
        if (ovf_q || (end_sum > Limit)) begin
          status_d = StOverflow;
        end else if (end_sum > SumW'(cap_q)) begin
          status_d = StCapacity;
        end else if (count_q >= MaxCnt) begin
          status_d = StStackFull;
        end else begin
          wr_en   = 1'b1;
          used_d  = end_sum[DataW-1:0];
          if (end_sum[DataW-1:0] > peak_q) begin
            peak_d = end_sum[DataW-1:0];
          end
          count_d = count_q + CntW'(1);
          goff_d  = off_q[DataW-1:0];
        end
      end

      // Fetch the top record, or finish on an empty stack
      SRwRd: begin
        if (count_q == '0) begin
          used_d  = mark_q;
          done_d  = 1'b1;
          state_d = SIdle;
        end else begin
          rd_en   = 1'b1;
          state_d = SRwChk;
        end
      end

      // Pop a record at or above the mark, else test for a split
      SRwChk: begin
        if (rd_data_q[DataW-1:0] >= mark_q) begin
          count_d = count_m1;
          state_d = SRwRd;
        end else begin
          done_d  = 1'b1;
          state_d = SIdle;
          if ({1'b0, mark_q} < top_end) begin
            status_d = StSplit;
          end else begin
            used_d = mark_q;
          end
        end
      end

      default: begin
        state_d = SIdle;
      end
    endcase
  end

  // Hold control state and configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SIdle;
      used_q  <= '0;
      peak_q  <= '0;
      count_q <= '0;
      done_q  <= 1'b0;
      cap_q   <= CapacityReset;
      align_q <= AlignmentReset;
    end else begin
      state_q <= state_d;
      used_q  <= used_d;
      peak_q  <= peak_d;
      count_q <= count_d;
      done_q  <= done_d;
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          CfgCapacity:  cap_q   <= cfg_data_i;
          CfgAlignment: align_q <= cfg_data_i[AlignW-1:0];
          default:      cap_q   <= cap_q;
        endcase
      end
    end
  end

  // Advance the datapath registers
  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    goff_q   <= goff_d;
    size_q   <= size_d;
    mark_q   <= mark_d;
    dvd_q    <= dvd_d;
    rem_q    <= rem_d;
    dcnt_q   <= dcnt_d;
    off_q    <= off_d;
    ovf_q    <= ovf_d;
  end

  // Record memory, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      rec_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_q <= rec_mem[rd_addr];
    end
  end

endmodule
